// ===== rtl/frpp_pkg.sv =====
// ----------------------------------------------------------------------------
// frpp_pkg
// Types, constants and helpers shared by the fixed-rate packet pacer.
// ----------------------------------------------------------------------------
package frpp_pkg;

    localparam int TIME_W   = 48;
    localparam int FLIGHT_W = 16;
    localparam int DELAY_W  = 24;
    localparam int GRAN_W   = 24;
    localparam int CREDIT_W = 8;
    localparam int CMD_W    = 3;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 24;
    localparam int IN_DW    = 96;
    localparam int OUT_DW   = 64;

    localparam logic [GRAN_W-1:0]   GRANULARITY_RST  = 24'd1000;
    localparam logic [CREDIT_W-1:0] BURST_CREDIT_RST = 8'd10;
    localparam logic [TIME_W-1:0]   TIME_MAX         = {TIME_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK_START = 3'd0,
        CMD_TICK_END   = 3'd1,
        CMD_CAN_SEND   = 3'd2,
        CMD_SCHEDULED  = 3'd3,
        CMD_LOSS       = 3'd4,
        CMD_PROBE      = 3'd5
    } cmd_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_GRANULARITY  = 1'b0,
        REG_BURST_CREDIT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [TIME_W-1:0]   time_now;
        logic [FLIGHT_W-1:0] flight_count;
        logic                recovering;
        logic [DELAY_W-1:0]  tx_delay;
    } item_t;

    typedef struct packed {
        logic [CREDIT_W-1:0] credit;
        logic [TIME_W-1:0]   next_time;
        logic [TIME_W-1:0]   last_delay_time;
        logic [TIME_W-1:0]   current_time;
        logic                sched_delayed;
        logic                delayed_at_tick;
        logic                scheduled_this_tick;
    } state_t;

    typedef struct packed {
        logic                decision;
        logic                delayed;
        logic [TIME_W-1:0]   next_send_time;
        logic [CREDIT_W-1:0] credit_left;
    } result_t;

    typedef struct packed {
        logic [GRAN_W-1:0]   granularity;
        logic [CREDIT_W-1:0] burst_credit;
    } cfg_t;

    function automatic logic [TIME_W-1:0] sat_add(
        input logic [TIME_W-1:0] a,
        input logic [TIME_W-1:0] b
    );
        logic [TIME_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/fixed_rate_packet_pacer.sv =====
// ----------------------------------------------------------------------------
// fixed_rate_packet_pacer
// Packet-send pacer with burst credit, one result beat per event beat.
// ----------------------------------------------------------------------------
// datapath: input register, then result register
// throughput: one beat per cycle unless m_tready stalls the result beat; the pacing state updates as
//   an event leaves the input register, so the next event sees it on the following cycle
// reset: asynchronous, active low; clears valids and pacing state, credit loads 10,
//   granularity 1000, burst_credit 10
module fixed_rate_packet_pacer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [frpp_pkg::IN_DW-1:0]      s_tdata,  // time_now, flight_count, recovering, tx_delay
    input  logic [frpp_pkg::CMD_W-1:0]      s_tuser,  // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [frpp_pkg::OUT_DW-1:0]     m_tdata,  // decision, delayed, next_send_time, credit_left
    input  logic                            cfg_we,
    input  logic [frpp_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [frpp_pkg::CFG_DW-1:0]     cfg_wdata
);

    frpp_pkg::cfg_t    cfg;
    frpp_pkg::item_t   in_item;
    frpp_pkg::item_t   item_reg;
    logic              in_valid_reg;
    frpp_pkg::state_t  state_reg;
    frpp_pkg::state_t  state_next;
    frpp_pkg::result_t res_next;
    frpp_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              fire;

    frpp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    frpp_step u_step
    (
        .item    (item_reg),
        .st      (state_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .res     (res_next)
    );

    assign in_item.cmd          = frpp_pkg::cmd_t'(s_tuser);
    assign in_item.time_now     = s_tdata[47:0];
    assign in_item.flight_count = s_tdata[63:48];
    assign in_item.recovering   = s_tdata[64];
    assign in_item.tx_delay     = s_tdata[88:65];

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{credit: frpp_pkg::BURST_CREDIT_RST, default: '0};
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= in_item;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, res_reg.credit_left, res_reg.next_send_time,
                       res_reg.delayed, res_reg.decision};

endmodule

// ===== rtl/frpp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// frpp_cfg_regs
// Write-only configuration registers of the pacer.
// ----------------------------------------------------------------------------
module frpp_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [frpp_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [frpp_pkg::CFG_DW-1:0]     cfg_wdata,
    output frpp_pkg::cfg_t                  cfg
);

    logic [frpp_pkg::GRAN_W-1:0]   granularity_reg;
    logic [frpp_pkg::CREDIT_W-1:0] burst_credit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            granularity_reg  <= frpp_pkg::GRANULARITY_RST;
            burst_credit_reg <= frpp_pkg::BURST_CREDIT_RST;
        end
        else if (cfg_we)
        begin
            case (frpp_pkg::cfg_reg_t'(cfg_addr))
                frpp_pkg::REG_GRANULARITY:
                begin
                    granularity_reg <= cfg_wdata[frpp_pkg::GRAN_W-1:0];
                end
                frpp_pkg::REG_BURST_CREDIT:
                begin
                    burst_credit_reg <= cfg_wdata[frpp_pkg::CREDIT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.granularity  = granularity_reg;
    assign cfg.burst_credit = burst_credit_reg;

endmodule

// ===== rtl/frpp_step.sv =====
// ----------------------------------------------------------------------------
// frpp_step
// Next-state and result logic for one pacer event.
// ----------------------------------------------------------------------------
module frpp_step
(
    input  frpp_pkg::item_t     item,
    input  frpp_pkg::state_t    st,
    input  frpp_pkg::cfg_t      cfg,
    output frpp_pkg::state_t    st_next,
    output frpp_pkg::result_t   res
);

    logic                          idle;
    logic                          refill;
    logic [frpp_pkg::CREDIT_W-1:0] credit_eff;
    logic [frpp_pkg::TIME_W-1:0]   delay_ext;
    logic [frpp_pkg::TIME_W-1:0]   next_plus_delay;
    logic [frpp_pkg::TIME_W-1:0]   cur_plus_delay;
    logic [frpp_pkg::TIME_W-1:0]   cur_plus_gran;
    logic [frpp_pkg::TIME_W-1:0]   cur_plus_half;
    logic [frpp_pkg::TIME_W-1:0]   last_plus_delay;
    logic                          idle_gap;
    logic                          catching_up;
    logic                          decision;

    assign idle       = (item.flight_count == '0);
    assign refill     = idle && !item.recovering;
    assign credit_eff = refill ? cfg.burst_credit : st.credit;
    assign delay_ext  = {{(frpp_pkg::TIME_W-frpp_pkg::DELAY_W){1'b0}}, item.tx_delay};

    assign next_plus_delay = frpp_pkg::sat_add(st.next_time, delay_ext);
    assign cur_plus_delay  = frpp_pkg::sat_add(st.current_time, delay_ext);
    assign last_plus_delay = frpp_pkg::sat_add(st.last_delay_time, delay_ext);
    assign cur_plus_gran   = frpp_pkg::sat_add(st.current_time,
        {{(frpp_pkg::TIME_W-frpp_pkg::GRAN_W){1'b0}}, cfg.granularity});
    assign cur_plus_half   = frpp_pkg::sat_add(st.current_time, delay_ext >> 1);

    assign idle_gap    = (st.last_delay_time != '0) && (last_plus_delay <= st.current_time);
    assign catching_up = (next_plus_delay <= st.current_time);

    always_comb
    begin
        st_next  = st;
        decision = 1'b0;
        case (item.cmd)
            frpp_pkg::CMD_TICK_START:
            begin
                st_next.current_time = item.time_now;
                if (st.sched_delayed)
                begin
                    st_next.delayed_at_tick = 1'b1;
                end
                st_next.scheduled_this_tick = 1'b0;
            end
            frpp_pkg::CMD_TICK_END:
            begin
                if (st.delayed_at_tick && !st.scheduled_this_tick
                    && (st.current_time > st.next_time))
                begin
                    st_next.sched_delayed = 1'b0;
                end
                st_next.delayed_at_tick = 1'b0;
            end
            frpp_pkg::CMD_CAN_SEND:
            begin
                if ((st.credit != '0) || idle)
                begin
                    decision = 1'b1;
                end
                else if (st.next_time > cur_plus_gran)
                begin
                    st_next.sched_delayed = 1'b1;
                end
                else
                begin
                    decision = 1'b1;
                end
            end
            frpp_pkg::CMD_SCHEDULED:
            begin
                st_next.scheduled_this_tick = 1'b1;
                st_next.credit = credit_eff;
                if (credit_eff != '0)
                begin
                    st_next.credit          = credit_eff - 8'd1;
                    st_next.sched_delayed   = 1'b0;
                    st_next.next_time       = '0;
                    st_next.last_delay_time = '0;
                end
                else if (st.sched_delayed)
                begin
                    st_next.next_time = next_plus_delay;
                    if (catching_up && !idle_gap)
                    begin
                        st_next.last_delay_time = st.current_time;
                    end
                    else
                    begin
                        st_next.sched_delayed   = 1'b0;
                        st_next.last_delay_time = '0;
                    end
                end
                else
                begin
                    st_next.next_time = (next_plus_delay > cur_plus_delay) ?
                        next_plus_delay : cur_plus_delay;
                end
            end
            frpp_pkg::CMD_LOSS:
            begin
                st_next.credit = '0;
            end
            frpp_pkg::CMD_PROBE:
            begin
                decision = (st.credit > 8'd1) || idle || (st.next_time > cur_plus_half);
            end
            default:
            begin
            end
        endcase
    end

    assign res.decision       = decision;
    assign res.delayed        = st_next.sched_delayed;
    assign res.next_send_time = st_next.next_time;
    assign res.credit_left    = st_next.credit;

endmodule

// ===== rtl/frpp_checker.sv =====
// ----------------------------------------------------------------------------
// frpp_checker
// Port-level checks for the fixed-rate packet pacer.
// ----------------------------------------------------------------------------
module frpp_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [frpp_pkg::OUT_DW-1:0]     m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input side only stalls behind a stalled full result register
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // pacing delay only arises with no credit left
    a_delay_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[57:50] == '0)
        else $error("delayed while credit remains");

    // while credit remains sends are unpaced
    a_credit_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[57:50] != '0) |-> m_tdata[49:2] == '0)
        else $error("next send time set while credit remains");

endmodule

bind fixed_rate_packet_pacer frpp_checker u_frpp_checker (.*);
